/* sv/srm_pkg.sv */
// ----------------------------------------------------------------------------
// srm_pkg
// Types and codes shared by the spatial relation matrix block.
// ----------------------------------------------------------------------------
package srm_pkg;

   localparam int CellCount = 9;
   localparam int CodeWidth = 3;

   typedef logic [CodeWidth-1:0] code_type;
   typedef logic [CellCount-1:0][CodeWidth-1:0] matrix_type;

   // cell codes, 3-bit two's complement
   localparam code_type CODE_TRUE  = 3'b110;
   localparam code_type CODE_FALSE = 3'b111;
   localparam code_type CODE_POINT = 3'b000;
   localparam code_type CODE_LINE  = 3'b001;
   localparam code_type CODE_AREA  = 3'b010;

   // geometry dimensions
   localparam logic [1:0] DIM_POINT = 2'd0;
   localparam logic [1:0] DIM_LINE  = 2'd1;
   localparam logic [1:0] DIM_AREA  = 2'd2;
   localparam logic [1:0] IDX_NONE  = 2'd3;

   typedef enum logic [2:0] {
      CMD_SET       = 3'd0,
      CMD_RAISE     = 3'd1,
      CMD_MERGE     = 3'd2,
      CMD_FILL      = 3'd3,
      CMD_TRANSPOSE = 3'd4,
      CMD_NONE      = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      SYM_ANY   = 3'd0,
      SYM_T     = 3'd1,
      SYM_F     = 3'd2,
      SYM_POINT = 3'd3,
      SYM_LINE  = 3'd4,
      SYM_AREA  = 3'd5
   } sym_type;

   typedef struct packed {
      logic disjoint;
      logic intersects;
      logic touches;
      logic crosses;
      logic lies_within;
      logic contains;
      logic equals;
      logic overlaps;
      logic covers;
      logic covered_by;
   } flags_type;

   // any dimension code, or the true code
   function automatic logic code_is_true(code_type v);
      return !v[CodeWidth-1] || (v == CODE_TRUE);
   endfunction

endpackage

/* sv/srm_update.sv */
// ----------------------------------------------------------------------------
// srm_update
// Applies one command to the current matrix and gives the next matrix.
// ----------------------------------------------------------------------------
module srm_update import srm_pkg::*; (
   input  matrix_type cur,
   input  logic [2:0] cmd,
   input  logic [1:0] row,
   input  logic [1:0] col,
   input  code_type   cell_value,
   input  matrix_type other_cells,
   output matrix_type next
);

   logic [3:0] idx;
   logic       idx_ok;

   assign idx    = 4'(row) * 4'd3 + 4'(col);
   assign idx_ok = (row != IDX_NONE) && (col != IDX_NONE);

   always_comb begin
      next = cur;
      unique case (cmd)
         CMD_SET: begin
            for (int k = 0; k < CellCount; k++) begin
               if (idx_ok && idx == 4'(k)) next[k] = cell_value;
            end
         end
         CMD_RAISE: begin
            for (int k = 0; k < CellCount; k++) begin
               if (idx_ok && idx == 4'(k) && $signed(cur[k]) < $signed(cell_value))
                  next[k] = cell_value;
            end
         end
         CMD_MERGE: begin
            for (int k = 0; k < CellCount; k++) begin
               if ($signed(cur[k]) < $signed(other_cells[k])) next[k] = other_cells[k];
            end
         end
         CMD_FILL: begin
            for (int k = 0; k < CellCount; k++) next[k] = cell_value;
         end
         CMD_TRANSPOSE: begin
            next[1] = cur[3];
            next[3] = cur[1];
            next[2] = cur[6];
            next[6] = cur[2];
            next[5] = cur[7];
            next[7] = cur[5];
         end
         default: begin
            next = cur;
         end
      endcase
   end

endmodule

/* sv/srm_eval.sv */
// ----------------------------------------------------------------------------
// srm_eval
// Pattern match and spatial predicates on one matrix.
// ----------------------------------------------------------------------------
module srm_eval import srm_pkg::*; (
   input  matrix_type m,
   input  logic [1:0] dim_a,
   input  logic [1:0] dim_b,
   input  matrix_type pattern,
   output logic       pattern_match,
   output flags_type  flags
);

   logic [CellCount-1:0] sym_hit;
   logic ii, ib, bi, bb, ie, ei, eb, be, common;
   logic ii_f, ie_f, ei_f;
   logic a_lt_b_cross, b_lt_a_cross;

   always_comb begin
      for (int k = 0; k < CellCount; k++) begin
         unique case (pattern[k])
            SYM_ANY:   sym_hit[k] = 1'b1;
            SYM_T:     sym_hit[k] = code_is_true(m[k]);
            SYM_F:     sym_hit[k] = (m[k] == CODE_FALSE);
            SYM_POINT: sym_hit[k] = (m[k] == CODE_POINT);
            SYM_LINE:  sym_hit[k] = (m[k] == CODE_LINE);
            SYM_AREA:  sym_hit[k] = (m[k] == CODE_AREA);
            default:   sym_hit[k] = 1'b0;
         endcase
      end
   end

   assign pattern_match = &sym_hit;

   // cell k = 3*row + col
   assign ii = code_is_true(m[0]);
   assign ib = code_is_true(m[1]);
   assign ie = code_is_true(m[2]);
   assign bi = code_is_true(m[3]);
   assign bb = code_is_true(m[4]);
   assign ei = code_is_true(m[6]);
   assign be = (m[5] == CODE_FALSE);
   assign eb = (m[7] == CODE_FALSE);
   assign ii_f = (m[0] == CODE_FALSE);
   assign ie_f = (m[2] == CODE_FALSE);
   assign ei_f = (m[6] == CODE_FALSE);
   assign common = ii || ib || bi || bb;

   assign a_lt_b_cross = (dim_a == DIM_POINT && (dim_b == DIM_LINE || dim_b == DIM_AREA))
                      || (dim_a == DIM_LINE && dim_b == DIM_AREA);
   assign b_lt_a_cross = (dim_b == DIM_POINT && (dim_a == DIM_LINE || dim_a == DIM_AREA))
                      || (dim_a == DIM_AREA && dim_b == DIM_LINE);

   always_comb begin
      flags.disjoint   = ii_f && (m[1] == CODE_FALSE) && (m[3] == CODE_FALSE)
                      && (m[4] == CODE_FALSE);
      flags.intersects = !flags.disjoint;
      flags.touches    = (dim_a != IDX_NONE) && (dim_b != IDX_NONE)
                      && !(dim_a == DIM_POINT && dim_b == DIM_POINT)
                      && ii_f && (ib || bi || bb);
      priority if (a_lt_b_cross)
         flags.crosses = ii && ie;
      else if (b_lt_a_cross)
         flags.crosses = ii && ei;
      else if (dim_a == DIM_LINE && dim_b == DIM_LINE)
         flags.crosses = (m[0] == CODE_POINT);
      else
         flags.crosses = 1'b0;
      priority if ((dim_a == DIM_POINT && dim_b == DIM_POINT)
                || (dim_a == DIM_AREA && dim_b == DIM_AREA))
         flags.overlaps = ii && ie && ei;
      else if (dim_a == DIM_LINE && dim_b == DIM_LINE)
         flags.overlaps = (m[0] == CODE_LINE) && ie && ei;
      else
         flags.overlaps = 1'b0;
      flags.lies_within = ii && ie_f && be;
      flags.contains   = ii && ei_f && eb;
      flags.equals     = (dim_a == dim_b) && ii && ei_f && ie_f && eb && be;
      flags.covers     = common && ei_f && eb;
      flags.covered_by = common && ie_f && be;
   end

endmodule

/* sv/spatial_relation_matrix.sv */
// ----------------------------------------------------------------------------
// spatial_relation_matrix
// DE-9IM intersection matrix with one update command and predicates per item.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the req_ fields and raise start; the item is taken at a clock edge
//   where start is high and busy is low. busy stays low, so an item can be
//   given in every cycle.
//   The item is registered at that edge. In the next cycle its command is
//   applied to the stored 3x3 matrix and the pattern match and predicates
//   are worked out on the updated matrix; matrix and result registers load
//   together at the following edge.
//   The result shows on the rsp_ ports with rsp_strobe high once the item has
//   passed through valid_ff and then strobe_ff, for exactly one cycle.
//   Throughput: one item per cycle, set by the update of the matrix register
//   that the next item reads.
//   The receiver cannot stall; a result not taken in its strobe cycle is gone.
//   Reset (synchronous) sets all nine cells to false and drops any item in
//   flight.
// ----------------------------------------------------------------------------
module spatial_relation_matrix import srm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [1:0]  req_row,
   input  logic [1:0]  req_col,
   input  logic signed [2:0] req_cell_value,
   input  logic [26:0] req_other_cells,
   input  logic [1:0]  req_dim_a,
   input  logic [1:0]  req_dim_b,
   input  logic [26:0] req_pattern,
   output logic        rsp_strobe,
   output logic [26:0] rsp_cells,
   output logic        rsp_pattern_match,
   output logic        rsp_is_disjoint,
   output logic        rsp_is_intersects,
   output logic        rsp_is_touches,
   output logic        rsp_is_crosses,
   output logic        rsp_is_within,
   output logic        rsp_is_contains,
   output logic        rsp_is_equals,
   output logic        rsp_is_overlaps,
   output logic        rsp_is_covers,
   output logic        rsp_is_covered_by
);

   logic       valid_ff;
   logic [2:0] cmd_ff;
   logic [1:0] row_ff, col_ff, dim_a_ff, dim_b_ff;
   code_type   value_ff;
   matrix_type other_ff, pattern_ff;

   matrix_type mat_ff, mat_in;
   logic       match_in;
   flags_type  flags_in;

   logic       strobe_ff;
   matrix_type cells_ff;
   logic       match_ff;
   flags_type  flags_ff;

   logic       accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         strobe_ff <= 1'b0;
         for (int k = 0; k < CellCount; k++) mat_ff[k] <= CODE_FALSE;
      end else begin
         valid_ff  <= accept;
         strobe_ff <= valid_ff;
         if (valid_ff) mat_ff <= mat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_cmd;
         row_ff     <= req_row;
         col_ff     <= req_col;
         value_ff   <= code_type'(req_cell_value);
         other_ff   <= matrix_type'(req_other_cells);
         dim_a_ff   <= req_dim_a;
         dim_b_ff   <= req_dim_b;
         pattern_ff <= matrix_type'(req_pattern);
      end
      if (valid_ff) begin
         cells_ff <= mat_in;
         match_ff <= match_in;
         flags_ff <= flags_in;
      end
   end

   srm_update u_update (
      .cur         (mat_ff),
      .cmd         (cmd_ff),
      .row         (row_ff),
      .col         (col_ff),
      .cell_value  (value_ff),
      .other_cells (other_ff),
      .next        (mat_in)
   );

   srm_eval u_eval (
      .m             (mat_in),
      .dim_a         (dim_a_ff),
      .dim_b         (dim_b_ff),
      .pattern       (pattern_ff),
      .pattern_match (match_in),
      .flags         (flags_in)
   );

   assign rsp_strobe        = strobe_ff;
   assign rsp_cells         = 27'(cells_ff);
   assign rsp_pattern_match = match_ff;
   assign rsp_is_disjoint   = flags_ff.disjoint;
   assign rsp_is_intersects = flags_ff.intersects;
   assign rsp_is_touches    = flags_ff.touches;
   assign rsp_is_crosses    = flags_ff.crosses;
   assign rsp_is_within     = flags_ff.lies_within;
   assign rsp_is_contains   = flags_ff.contains;
   assign rsp_is_equals     = flags_ff.equals;
   assign rsp_is_overlaps   = flags_ff.overlaps;
   assign rsp_is_covers     = flags_ff.covers;
   assign rsp_is_covered_by = flags_ff.covered_by;

   // every accepted item gives its result, passed on through valid_ff and strobe_ff
   a_item_to_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("accepted item produced no result");

   // no result without an accepted item passed on through valid_ff and strobe_ff
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("result without an accepted item");

   // the reported matrix is the one that stays stored
   a_cells_match_state: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (cells_ff == mat_ff))
      else $error("reported matrix differs from stored matrix");

   // matrix changes only while an item is being worked on
   a_state_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |=> $stable(mat_ff))
      else $error("matrix changed with no item in flight");

   // equality implies both within and contains
   a_equals_implies: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_equals) |-> (rsp_is_within && rsp_is_contains))
      else $error("equals without within and contains");

endmodule
